// ===== sv/ffpd_pkg.sv =====
// Shared types and constants for the fixed frame position deframer.
package ffpd_pkg;

    // frame geometry
    localparam int unsigned FRAME_BYTES = 8;
    localparam int unsigned POS_W       = $clog2(FRAME_BYTES);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

    // offset removed from the x and y words
    localparam logic [15:0] XY_OFFSET = 16'h8000;

    // request codes
    localparam logic [2:0] REQ_BYTE    = 3'd0;
    localparam logic [2:0] REQ_IDLE    = 3'd1;
    localparam logic [2:0] REQ_OVERRUN = 3'd2;
    localparam logic [2:0] REQ_CONSUME = 3'd3;
    localparam logic [2:0] REQ_CLEAR   = 3'd4;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 2'd2;

    // configuration reset values
    localparam logic [7:0] HEAD_RESET  = 8'h7B;
    localparam logic [7:0] TAIL_RESET  = 8'h7D;
    localparam logic [7:0] SCALE_RESET = 8'd10;

    // one result beat
    typedef struct packed {
        logic               frame_good;
        logic               frame_bad;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [15:0]        area_value;
        logic               data_ready;
        logic [15:0]        frame_total;
        logic [7:0]         overrun_value;
    } t_result;

    // configuration write
    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] idx;
        logic [7:0]           data;
    } t_cfg_wr;

endpackage

// ===== sv/ffpd_core.sv =====
// Input register, frame collection, check and held-value update.
module ffpd_core
    import ffpd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg_wr i_cfg,
    input  logic    i_valid,
    input  logic [2:0] i_req_type,
    input  logic [7:0] i_rx_byte,
    output logic    o_stall,
    input  logic    i_q_full,
    output logic    o_push,
    output t_result o_result
);

    // configuration
    logic [7:0] r_head;
    logic [7:0] r_tail;
    logic [7:0] r_scale;

    // input register
    logic       r_in_valid;
    logic [2:0] r_req;
    logic [7:0] r_byte;

    // block state
    logic [POS_W-1:0] r_pos,   n_pos;
    logic [7:0]       r_fb [FRAME_BYTES];
    logic [15:0]      r_x,     n_x;
    logic [15:0]      r_y,     n_y;
    logic [15:0]      r_area,  n_area;
    logic             r_ready, n_ready;
    logic [15:0]      r_total, n_total;
    logic [7:0]       r_ovr,   n_ovr;
    logic             n_good;
    logic             n_bad;

    logic        w_accept;
    logic [15:0] w_word_x;
    logic [15:0] w_word_y;
    logic [15:0] w_word_a;
    logic [23:0] w_prod;

    // write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= HEAD_RESET;
            r_tail  <= TAIL_RESET;
            r_scale <= SCALE_RESET;
        end else if (i_cfg.we) begin
            case (i_cfg.idx)
                CFG_HEAD:  r_head  <= i_cfg.data;
                CFG_TAIL:  r_tail  <= i_cfg.data;
                CFG_SCALE: r_scale <= i_cfg.data;
                default:   ;
            endcase
        end
    end

    // input handshake: hold the beat while the result queue is full
    assign o_stall  = r_in_valid && i_q_full;
    assign w_accept = i_valid && !o_stall;
    assign o_push   = r_in_valid && !i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (o_push) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req  <= i_req_type;
            r_byte <= i_rx_byte;
        end
    end

    // big-endian words of the frame; the tail byte is the current beat
    assign w_word_x = {r_fb[1], r_fb[2]};
    assign w_word_y = {r_fb[3], r_fb[4]};
    assign w_word_a = {r_fb[5], r_fb[6]};
    assign w_prod   = {8'd0, w_word_a} * {16'd0, r_scale};

    // next state for the registered beat
    always_comb begin
        n_pos   = r_pos;
        n_x     = r_x;
        n_y     = r_y;
        n_area  = r_area;
        n_ready = r_ready;
        n_total = r_total;
        n_ovr   = r_ovr;
        n_good  = 1'b0;
        n_bad   = 1'b0;
        case (r_req)
            REQ_BYTE: begin
                if (r_pos == LAST_POS) begin
                    n_pos = '0;
                    if (r_fb[0] == r_head && r_byte == r_tail) begin
                        n_x     = w_word_x - XY_OFFSET;
                        n_y     = w_word_y - XY_OFFSET;
                        n_area  = w_prod[15:0];
                        n_ready = 1'b1;
                        n_total = r_total + 16'd1;
                        n_good  = 1'b1;
                    end else begin
                        n_bad = 1'b1;
                    end
                end else begin
                    n_pos = r_pos + POS_W'(1);
                end
            end
            REQ_IDLE:    n_pos = '0;
            REQ_OVERRUN: begin
                n_ovr = r_byte;
                n_pos = '0;
            end
            REQ_CONSUME: n_ready = 1'b0;
            REQ_CLEAR: begin
                n_ready = 1'b0;
                n_pos   = '0;
            end
            default: ;
        endcase
    end

    // advance state when the beat moves into the result queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_x     <= '0;
            r_y     <= '0;
            r_area  <= '0;
            r_ready <= 1'b0;
            r_total <= '0;
            r_ovr   <= '0;
        end else if (o_push) begin
            r_pos   <= n_pos;
            r_x     <= n_x;
            r_y     <= n_y;
            r_area  <= n_area;
            r_ready <= n_ready;
            r_total <= n_total;
            r_ovr   <= n_ovr;
        end
    end

    // store frame bytes
    always_ff @(posedge i_clk) begin
        if (o_push && r_req == REQ_BYTE) begin
            r_fb[r_pos] <= r_byte;
        end
    end

    assign o_result.frame_good    = n_good;
    assign o_result.frame_bad     = n_bad;
    assign o_result.pos_x         = n_x;
    assign o_result.pos_y         = n_y;
    assign o_result.area_value    = n_area;
    assign o_result.data_ready    = n_ready;
    assign o_result.frame_total   = n_total;
    assign o_result.overrun_value = n_ovr;

    // a completed frame is either good or bad, never both
    a_good_bad_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !(n_good && n_bad))
        else $error("frame flagged good and bad");

    // collection restarts after the last byte of a frame
    a_pos_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && r_req == REQ_BYTE && r_pos == LAST_POS) |=> (r_pos == '0))
        else $error("byte position did not restart");

    // the good-frame count moves only on a good frame
    a_total_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_push && n_good) |=> $stable(r_total))
        else $error("frame count changed without a good frame");

endmodule

// ===== sv/ffpd_outq.sv =====
// Two-entry result queue that parts the core from the output handshake.
module ffpd_outq
    import ffpd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_result,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_result
);

    t_result    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_pop;

    assign o_valid  = (r_count != 2'd0);
    assign o_full   = (r_count == 2'd2);
    assign w_pop    = o_valid && !i_stall;
    assign o_result = r_mem[r_rd_ptr];

    // track pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: ;
            endcase
        end
    end

    // write the entry
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_result;
        end
    end

    // no push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full result queue");

    // fill level agrees with the pointers
    a_count_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'd2) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with fill level");

    // fill level stays within the two entries
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("queue fill level out of range");

endmodule

// ===== sv/fixed_frame_position_deframer.sv =====
// Top level of the fixed frame position deframer.
//
//  channel | direction | handshake          | beat contents
//  --------+-----------+--------------------+--------------------------------------
//  in      | input     | i_valid / o_stall  | i_req_type, i_rx_byte
//  out     | output    | o_valid / i_stall  | frame flags, x, y, area, ready, totals
//  cfg     | input     | i_cfg_we           | i_cfg_idx, i_cfg_data
//
// Each beat is held in the input register, then passes through the frame
// check and area multiply into the queue.
// One beat per cycle is sustained while i_stall is low; the two-entry result
// queue lets a new beat in while a result waits.
// Synchronous active-low reset clears control state and restores the configuration reset values.
// A stall on the output backs up the queue and then raises o_stall.
module fixed_frame_position_deframer
    import ffpd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]           i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [2:0]           i_req_type,
    input  logic [7:0]           i_rx_byte,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_frame_good,
    output logic                 o_frame_bad,
    output logic signed [15:0]   o_pos_x,
    output logic signed [15:0]   o_pos_y,
    output logic [15:0]          o_area_value,
    output logic                 o_data_ready,
    output logic [15:0]          o_frame_total,
    output logic [7:0]           o_overrun_value
);

    t_cfg_wr w_cfg;
    t_result w_core_res;
    t_result w_out_res;
    logic    w_push;
    logic    w_q_full;

    assign w_cfg.we   = i_cfg_we;
    assign w_cfg.idx  = i_cfg_idx;
    assign w_cfg.data = i_cfg_data;

    // frame collection and check
    ffpd_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_valid    (i_valid),
        .i_req_type (i_req_type),
        .i_rx_byte  (i_rx_byte),
        .o_stall    (o_stall),
        .i_q_full   (w_q_full),
        .o_push     (w_push),
        .o_result   (w_core_res)
    );

    // result queue
    ffpd_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_result (w_core_res),
        .o_full   (w_q_full),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (w_out_res)
    );

    assign o_frame_good    = w_out_res.frame_good;
    assign o_frame_bad     = w_out_res.frame_bad;
    assign o_pos_x         = w_out_res.pos_x;
    assign o_pos_y         = w_out_res.pos_y;
    assign o_area_value    = w_out_res.area_value;
    assign o_data_ready    = w_out_res.data_ready;
    assign o_frame_total   = w_out_res.frame_total;
    assign o_overrun_value = w_out_res.overrun_value;

endmodule
